FILE: hdl/gbne_pkg.sv
// Shared types and constants for the grid bin neighbor enumerator.
// Used by gbne_ctrl, gbne_dp and grid_bin_neighbor_enumerator_unit; no dependencies.
`default_nettype none

package gbne_pkg;

	localparam int IDX_W  = 21;
	localparam int GRES_W = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [GRES_W-1:0] GRID_RES_RESET = 8'd100;

	// Register index taken from paddr[2].
	localparam logic REG_GRID_RES = 1'b0;

	typedef struct packed {
		logic load;
		logic calc_plane;
		logic calc_cells;
		logic div_x_init;
		logic div_step;
		logic div_y_init;
		logic set_start;
		logic emit_invalid;
		logic emit_next;
	} gbne_cmd_t;

	typedef struct packed {
		logic in_grid;
		logic last_pos;
	} gbne_stat_t;

endpackage

`default_nettype wire

FILE: hdl/grid_bin_neighbor_enumerator_unit.sv
// Top level of the grid bin neighbor enumerator: register port, controller and datapath.
// Depends on gbne_pkg, gbne_ctrl and gbne_dp.
`default_nettype none

// For each flat bin index the block returns the indices of the bin and its
// one-ring neighbors in a cubic grid of grid_res bins per axis, x outermost and
// z innermost, clipped at the faces, with last set on the final one. An index
// at or beyond grid_res cubed gives a single result with index_valid low, sent
// from the range check once the output register is free. Otherwise each item
// has a setup of the input transfer, two multiplies, the range check, two
// restoring divisions at one quotient bit per cycle and the start point, then
// one cycle per result while the output is taken. A new item is taken once
// the final result of the previous one sits in the output register. Write
// grid_res only while idle.
module grid_bin_neighbor_enumerator_unit #(
	parameter int MAX_RES = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gbne_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [gbne_pkg::DATA_W-1:0]  pwdata,
	output logic [gbne_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [gbne_pkg::IDX_W-1:0]   bin_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [gbne_pkg::IDX_W-1:0]        neighbor_index,
	output logic                              index_valid,
	output logic                              last
);
	import gbne_pkg::*;

	logic [GRES_W-1:0] grid_res_q;
	logic              reg_sel;
	gbne_cmd_t         cmd;
	gbne_stat_t        stat;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_GRID_RES);
	assign prdata  = reg_sel ? DATA_W'(grid_res_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_res_q <= GRID_RES_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			grid_res_q <= pwdata[GRES_W-1:0];
		end
	end

	gbne_ctrl #(
		.MAX_RES(MAX_RES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gbne_dp #(
		.MAX_RES(MAX_RES)
	) u_dp (
		.clk            (clk),
		.grid_res       (grid_res_q),
		.bin_index      (bin_index),
		.cmd            (cmd),
		.stat           (stat),
		.neighbor_index (neighbor_index),
		.index_valid    (index_valid),
		.last           (last)
	);

endmodule

`default_nettype wire

FILE: hdl/gbne_dp.sv
// Datapath: grid sizes, shared restoring divider, neighbor walk and result register.
// Depends on gbne_pkg; driven by commands from gbne_ctrl.
`default_nettype none

module gbne_dp #(
	parameter int MAX_RES = 128
) (
	input  wire logic                         clk,
	input  wire logic [gbne_pkg::GRES_W-1:0]  grid_res,
	input  wire logic [gbne_pkg::IDX_W-1:0]   bin_index,
	input  wire gbne_pkg::gbne_cmd_t          cmd,
	output gbne_pkg::gbne_stat_t              stat,
	output logic [gbne_pkg::IDX_W-1:0]        neighbor_index,
	output logic                              index_valid,
	output logic                              last
);
	import gbne_pkg::*;

	localparam int RW = $clog2(MAX_RES + 1);
	localparam int PW = 2 * RW;
	localparam int CW = 3 * RW;
	localparam int AW = ((CW > IDX_W) ? CW : IDX_W) + 1;
	localparam logic [GRES_W-1:0] MAX_RES_B = GRES_W'(MAX_RES);

	logic [RW-1:0]    res_eff;
	logic [RW-1:0]    res_q;
	logic [PW-1:0]    plane_q;
	logic [CW-1:0]    cells_q;
	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0]    rem_q;
	logic [AW-1:0]    dsh_q;
	logic [RW-1:0]    quo_q;
	logic [RW-1:0]    cx_q;
	logic [AW-1:0]    xbase_q;
	logic [AW-1:0]    ybase_q;
	logic [AW-1:0]    cur_q;
	logic [1:0]       i_q, j_q, k_q;
	logic [1:0]       imax_q, jmax_q, kmax_q;
	logic [AW-1:0]    start;
	logic [AW-1:0]    ybase_nx;
	logic [AW-1:0]    xbase_nx;
	logic [RW-1:0]    res_m1;
	logic             geq;

	// A resolution of zero acts as one, and anything above the maximum saturates.
	always_comb begin
		if (grid_res == '0) begin
			res_eff = RW'(1);
		end else if (grid_res > MAX_RES_B) begin
			res_eff = RW'(MAX_RES);
		end else begin
			res_eff = grid_res[RW-1:0];
		end
	end

	assign res_m1   = res_q - RW'(1);
	assign geq      = (rem_q >= dsh_q);
	assign ybase_nx = ybase_q + AW'(res_q);
	assign xbase_nx = xbase_q + AW'(plane_q);

	// First neighbor: step back one along every axis that is not at its low face.
	assign start = AW'(idx_q)
		- ((cx_q != '0) ? AW'(plane_q) : '0)
		- ((quo_q != '0) ? AW'(res_q) : '0)
		- ((rem_q != '0) ? AW'(1) : '0);

	assign stat.in_grid  = (AW'(idx_q) < AW'(cells_q));
	assign stat.last_pos = (i_q == imax_q) && (j_q == jmax_q) && (k_q == kmax_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= bin_index;
			res_q <= res_eff;
		end
		if (cmd.calc_plane) begin
			plane_q <= PW'(res_q) * PW'(res_q);
		end
		if (cmd.calc_cells) begin
			cells_q <= CW'(plane_q) * CW'(res_q);
		end

		// The quotient of either division fits in RW bits, so RW steps suffice.
		if (cmd.div_x_init) begin
			rem_q <= AW'(idx_q);
			dsh_q <= AW'(plane_q) << (RW - 1);
			quo_q <= '0;
		end else if (cmd.div_y_init) begin
			cx_q  <= quo_q;
			dsh_q <= AW'(res_q) << (RW - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (geq) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[RW-2:0], geq};
			dsh_q <= dsh_q >> 1;
		end

		if (cmd.set_start) begin
			xbase_q <= start;
			ybase_q <= start;
			cur_q   <= start;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			imax_q  <= 2'd2 - {1'b0, cx_q == '0} - {1'b0, cx_q == res_m1};
			jmax_q  <= 2'd2 - {1'b0, quo_q == '0} - {1'b0, quo_q == res_m1};
			kmax_q  <= 2'd2 - {1'b0, rem_q[RW-1:0] == '0}
				- {1'b0, rem_q[RW-1:0] == res_m1};
		end else if (cmd.emit_next) begin
			if (k_q != kmax_q) begin
				k_q   <= k_q + 2'd1;
				cur_q <= cur_q + AW'(1);
			end else if (j_q != jmax_q) begin
				j_q     <= j_q + 2'd1;
				k_q     <= '0;
				ybase_q <= ybase_nx;
				cur_q   <= ybase_nx;
			end else begin
				i_q     <= i_q + 2'd1;
				j_q     <= '0;
				k_q     <= '0;
				xbase_q <= xbase_nx;
				ybase_q <= xbase_nx;
				cur_q   <= xbase_nx;
			end
		end

		if (cmd.emit_invalid) begin
			neighbor_index <= '0;
			index_valid    <= 1'b0;
			last           <= 1'b1;
		end else if (cmd.emit_next) begin
			neighbor_index <= cur_q[IDX_W-1:0];
			index_valid    <= 1'b1;
			last           <= stat.last_pos;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/gbne_ctrl.sv
// Controller state machine: sequences setup, both divisions and the neighbor walk.
// Depends on gbne_pkg; commands gbne_dp and owns the result valid flag.
`default_nettype none

module gbne_ctrl #(
	parameter int MAX_RES = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire gbne_pkg::gbne_stat_t stat,
	output gbne_pkg::gbne_cmd_t       cmd
);
	import gbne_pkg::*;

	localparam int RW    = $clog2(MAX_RES + 1);
	localparam int CNT_W = $clog2(RW);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PLANE,
		S_CELLS,
		S_CHECK,
		S_DIVX,
		S_YINIT,
		S_DIVY,
		S_START,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              slot_free;
	logic              in_xfer;
	logic              emit;
	logic              step_done;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;
	assign step_done = (cnt_q == CNT_W'(RW - 1));
	assign emit      = cmd.emit_invalid || cmd.emit_next;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = in_xfer;
			S_PLANE: cmd.calc_plane = 1'b1;
			S_CELLS: cmd.calc_cells = 1'b1;
			S_CHECK: begin
				cmd.div_x_init   = stat.in_grid;
				cmd.emit_invalid = !stat.in_grid && slot_free;
			end
			S_DIVX:  cmd.div_step = 1'b1;
			S_YINIT: cmd.div_y_init = 1'b1;
			S_DIVY:  cmd.div_step = 1'b1;
			S_START: cmd.set_start = 1'b1;
			S_EMIT:  cmd.emit_next = slot_free;
			default: cmd = '0;
		endcase
	end

	// In the last y step the divider still steps, so the start point is taken
	// in S_START, once the final quotient bit is in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_PLANE;
					end
				end
				S_PLANE: state_q <= S_CELLS;
				S_CELLS: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.in_grid) begin
						cnt_q   <= '0;
						state_q <= S_DIVX;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIVX: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (step_done) begin
						state_q <= S_YINIT;
					end
				end
				S_YINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (step_done) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free && stat.last_pos) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/gbne_checker.sv
// Scoreboard for the grid bin neighbor enumerator: watches the register port and both channels.
// Predicts the neighbor list of every accepted bin index and compares each result transfer.
// Depends on gbne_pkg.
module gbne_checker #(
	parameter int MAX_RES = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gbne_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [gbne_pkg::DATA_W-1:0]  pwdata,
	input  wire logic [gbne_pkg::DATA_W-1:0]  prdata,
	input  wire logic                         pready,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [gbne_pkg::IDX_W-1:0]   bin_index,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [gbne_pkg::IDX_W-1:0]   neighbor_index,
	input  wire logic                         index_valid,
	input  wire logic                         last,
	output int                                mismatches,
	output int                                pending,
	output int                                bins_seen,
	output int                                neighbors_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import gbne_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] nbr;
		logic             valid;
		logic             last;
	} neighbor_t;

	neighbor_t                 neighbor_q[$];
	logic [GRES_W-1:0]         res_reg;
	int                        err_cnt;
	int                        bin_cnt;
	int                        nbr_cnt;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_cnt++;
	endtask

	// Pushes the expected neighbor list of one bin index, x outermost and z innermost.
	function automatic void predict_neighbors(input logic [IDX_W-1:0] idx);
		int        res, plane, cells, cx, cy, cz;
		int        lox, hix, loy, hiy, loz, hiz;
		neighbor_t e;
		res = int'(res_reg);
		if (res == 0) res = 1;
		if (res > MAX_RES) res = MAX_RES;
		plane = res * res;
		cells = plane * res;
		if (int'(idx) >= cells) begin
			e.nbr = '0;
			e.valid = 1'b0;
			e.last = 1'b1;
			neighbor_q.insert(neighbor_q.size(), e);
			return;
		end
		cx = int'(idx) / plane;
		cy = (int'(idx) - cx * plane) / res;
		cz = int'(idx) % res;
		lox = (cx == 0) ? 0 : -1;
		loy = (cy == 0) ? 0 : -1;
		loz = (cz == 0) ? 0 : -1;
		hix = (cx == res - 1) ? 0 : 1;
		hiy = (cy == res - 1) ? 0 : 1;
		hiz = (cz == res - 1) ? 0 : 1;
		for (int i = lox; i <= hix; i++) begin
			for (int j = loy; j <= hiy; j++) begin
				for (int k = loz; k <= hiz; k++) begin
					e.nbr = IDX_W'((cx + i) * plane + (cy + j) * res + (cz + k));
					e.valid = 1'b1;
					e.last = (i == hix) && (j == hiy) && (k == hiz);
					neighbor_q.insert(neighbor_q.size(), e);
				end
			end
		end
	endfunction

	// Counts are published with nonblocking updates after this edge's work, so the
	// stimulus side reads settled values.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_reg = GRID_RES_RESET;
			neighbor_q.delete();
		end else begin
			if (psel && penable && pready && paddr[2] == REG_GRID_RES) begin
				if (pwrite) begin
					res_reg = pwdata[GRES_W-1:0];
				end else if (prdata !== {{(DATA_W-GRES_W){1'b0}}, res_reg}) begin
					report_mismatch($sformatf("grid_res read back %0h, expected %0h",
						prdata, res_reg));
				end
			end
			if (in_valid && in_ready) begin
				predict_neighbors(bin_index);
				bin_cnt++;
			end
			if (out_valid && out_ready) begin
				nbr_cnt++;
				if (neighbor_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing outstanding",
						neighbor_index));
				end else begin
					neighbor_t e;
					e = neighbor_q.pop_front();
					if (neighbor_index !== e.nbr)
						report_mismatch($sformatf("neighbor_index %0d, expected %0d",
							neighbor_index, e.nbr));
					if (index_valid !== e.valid)
						report_mismatch($sformatf("index_valid %b, expected %b (index %0d)",
							index_valid, e.valid, e.nbr));
					if (last !== e.last)
						report_mismatch($sformatf("last %b, expected %b (index %0d)",
							last, e.last, e.nbr));
				end
			end
		end
		mismatches <= err_cnt;
		pending <= neighbor_q.size();
		bins_seen <= bin_cnt;
		neighbors_seen <= nbr_cnt;
	end

	initial begin
		err_cnt = 0;
		bin_cnt = 0;
		nbr_cnt = 0;
		mismatches = 0;
		pending = 0;
		bins_seen = 0;
		neighbors_seen = 0;
	end

endmodule

FILE: tb/sv/tb_grid_bin_neighbor_enumerator_unit.sv
// Testbench top for grid_bin_neighbor_enumerator_unit: clock, reset, register writes and bin indices.
// Results are judged by gbne_checker; depends on gbne_pkg, gbne_checker and the block itself.
module tb_grid_bin_neighbor_enumerator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import gbne_pkg::*;

	localparam int MAX_RES = 128;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDX_MAX = (1 << IDX_W) - 1;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 25;
	localparam logic [ADDR_W-1:0] GRID_RES_ADDR = {REG_GRID_RES, 2'b00};
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {~REG_GRID_RES, 2'b00};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [IDX_W-1:0]  bin_index;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  neighbor_index;
	logic              index_valid;
	logic              last;

	int                mismatches;
	int                pending;
	int                bins_seen;
	int                neighbors_seen;
	int                cycle_count;
	int                stall_left;
	int                settings_used;
	bit                calm;
	logic [GRES_W-1:0] cur_res;

	grid_bin_neighbor_enumerator_unit #(.MAX_RES(MAX_RES)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .bin_index(bin_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.neighbor_index(neighbor_index), .index_valid(index_valid), .last(last)
	);

	gbne_checker #(.MAX_RES(MAX_RES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .bin_index(bin_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.neighbor_index(neighbor_index), .index_valid(index_valid), .last(last),
		.mismatches(mismatches), .pending(pending),
		.bins_seen(bins_seen), .neighbors_seen(neighbors_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("grid_bin_neighbor_enumerator_unit regression: fail");
			$finish;
		end
	end

	// Result side: mostly short stalls, now and then a long one, none in calm phases.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm) begin
				case ($urandom_range(0, 99)) inside
					[0:19]: stall_left <= $urandom_range(1, 3);
					[20:22]: stall_left <= $urandom_range(8, 30);
					default: stall_left <= 0;
				endcase
			end
		end
	end

	function automatic int gap_cycles();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic int pick_coord(input int r);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return r - 1;
			default: return $urandom_range(0, r - 1);
		endcase
	endfunction

	// Mostly indices inside the current grid, a good share on faces and corners,
	// and some over the whole field range or just past the last bin.
	function automatic logic [IDX_W-1:0] pick_index();
		int r, cells, p;
		r = int'(cur_res);
		if (r == 0) r = 1;
		if (r > MAX_RES) r = MAX_RES;
		cells = r * r * r;
		p = $urandom_range(0, 99);
		if (p < 60) return IDX_W'($urandom_range(0, cells - 1));
		if (p < 85) return IDX_W'(pick_coord(r) * r * r + pick_coord(r) * r + pick_coord(r));
		if (p < 95 || cells > IDX_MAX) return IDX_W'($urandom_range(0, IDX_MAX));
		if (cells + 15 > IDX_MAX) return IDX_W'(IDX_MAX);
		return IDX_W'(cells + $urandom_range(0, 15));
	endfunction

	task automatic send_bin(input logic [IDX_W-1:0] v);
		int g;
		g = gap_cycles();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		bin_index <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic bus_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Only the low byte is the register; the upper bits of the word are random.
	task automatic set_grid_res(input logic [GRES_W-1:0] val);
		logic [DATA_W-1:0] word;
		word = $urandom();
		word[GRES_W-1:0] = val;
		wait_idle();
		bus_xfer(1'b1, GRID_RES_ADDR, word);
		bus_xfer(1'b0, GRID_RES_ADDR, '0);
		cur_res = val;
		settings_used++;
	endtask

	initial begin
		logic [GRES_W-1:0] phase_res[PHASES];
		cycle_count = 0;
		stall_left = 0;
		settings_used = 1;
		calm = 1'b0;
		cur_res = GRID_RES_RESET;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		bin_index = '0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset resolution: corners, faces, interior, first bin past the grid, largest index.
		send_bin(21'd0);
		send_bin(21'd999999);
		send_bin(21'd1000000);
		send_bin(21'(IDX_MAX));
		send_bin(21'd505050);
		send_bin(21'd99);
		send_bin(21'd9900);
		send_bin(21'd990000);
		send_bin(21'd123456);
		// Single-bin grid.
		set_grid_res(8'd1);
		send_bin(21'd0);
		send_bin(21'd1);
		send_bin(21'(IDX_MAX));
		// Largest grid fills the whole index range.
		set_grid_res(8'(MAX_RES));
		send_bin(21'd0);
		send_bin(21'(IDX_MAX));
		send_bin(21'd1234567);
		// Zero is taken as one, and values above the maximum saturate.
		set_grid_res(8'd0);
		send_bin(21'd0);
		send_bin(21'd8);
		set_grid_res(8'hFF);
		send_bin(21'(IDX_MAX - 1));
		// A write to the unmapped register must leave grid_res alone.
		wait_idle();
		bus_xfer(1'b1, UNMAPPED_ADDR, $urandom());
		send_bin(21'(IDX_MAX - 1));

		phase_res = '{8'd2, 8'd3, 8'(MAX_RES), 8'd5, 8'hFF, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph >= 7) phase_res[ph] = 8'($urandom_range(4, MAX_RES - 1));
			set_grid_res(phase_res[ph]);
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) send_bin(pick_index());
		end

		wait_idle();
		calm = 1'b0;
		repeat (64) @(posedge clk);
		$display("Covered %0d bin indices and %0d neighbor results over %0d grid_res settings,",
			bins_seen, neighbors_seen, settings_used);
		$display("with corner, face, interior and out-of-grid indices and random gaps on both sides.");
		if (mismatches == 0) begin
			$display("grid_bin_neighbor_enumerator_unit regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("grid_bin_neighbor_enumerator_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/gbne_pkg.sv
hdl/gbne_dp.sv
hdl/gbne_ctrl.sv
hdl/grid_bin_neighbor_enumerator_unit.sv
tb/sv/gbne_checker.sv
tb/sv/tb_grid_bin_neighbor_enumerator_unit.sv
